// ===== src/sdbi_pkg.sv =====
// ----------------------------------------------------------------------------
// sdbi_pkg
// Shared types for the signed divide-by-invariant block: the state encoding
// of the magic derivation sequencer and its status bundle.
// ----------------------------------------------------------------------------
package sdbi_pkg;

  // Magic derivation sequencer states
  typedef enum logic [1:0] {
    DV_IDLE,  // magic values valid
    DV_LOG,   // searching l = ceil(log2 |d|)
    DV_DIV    // restoring long division of 2^(W+l-1) by |d|
  } dv_state_e;

  // Status from the derivation unit to the datapath
  typedef struct packed {
    logic busy;      // derivation in progress, magic not yet usable
    logic div_neg;   // divisor is negative
    logic div_zero;  // divisor is zero
  } dv_status_t;

endpackage

// ===== src/sdbi_magic.sv =====
// ----------------------------------------------------------------------------
// sdbi_magic
// Derives the magic multiplier and post-shift from a written divisor with a
// bit-serial search for l followed by a one-bit-per-cycle long division.
// ----------------------------------------------------------------------------
module sdbi_magic #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          divisor_we_i,
  input  logic [DATA_WIDTH-1:0]         divisor_wdata_i,
  output logic [DATA_WIDTH-1:0]         magic_o,
  output logic [$clog2(DATA_WIDTH)-1:0] shift_o,
  output sdbi_pkg::dv_status_t          status_o
);

  localparam int LW = $clog2(DATA_WIDTH);
  localparam int CW = $clog2(2 * DATA_WIDTH);

  sdbi_pkg::dv_state_e state_q, state_d;

  logic [DATA_WIDTH-1:0] magic_q, magic_d;
  logic [LW-1:0]         shift_q, shift_d;
  logic                  neg_q, neg_d;
  logic                  zero_q, zero_d;

  // sequencer payload
  logic [DATA_WIDTH-1:0] abs_q, abs_d;
  logic [DATA_WIDTH-1:0] pow_q, pow_d;
  logic [DATA_WIDTH-1:0] rem_q, rem_d;
  logic [DATA_WIDTH-1:0] quo_q, quo_d;
  logic [LW-1:0]         l_q, l_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  first_q, first_d;

  logic [DATA_WIDTH-1:0] wr_abs;
  logic [DATA_WIDTH-1:0] rem_sh;
  logic                  rem_ge;
  logic [DATA_WIDTH-1:0] quo_nxt;
  logic [LW-1:0]         l_fix;

  // |d|; the most negative value maps to 2^(W-1) as an unsigned magnitude
  assign wr_abs  = divisor_wdata_i[DATA_WIDTH-1] ? (~divisor_wdata_i + 1'b1)
                                                 : divisor_wdata_i;
  // remainder stays below |d| <= 2^(W-1), so the dropped top bit is zero
  assign rem_sh  = {rem_q[DATA_WIDTH-2:0], first_q};
  assign rem_ge  = (rem_sh >= abs_q);
  assign quo_nxt = {quo_q[DATA_WIDTH-2:0], rem_ge};
  assign l_fix   = (l_q == '0) ? LW'(1) : l_q;

  always_comb begin
    state_d = state_q;
    magic_d = magic_q;
    shift_d = shift_q;
    neg_d   = neg_q;
    zero_d  = zero_q;
    abs_d   = abs_q;
    pow_d   = pow_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    l_d     = l_q;
    cnt_d   = cnt_q;
    first_d = first_q;

    unique case (state_q)
      sdbi_pkg::DV_IDLE: ;
      sdbi_pkg::DV_LOG: begin
        if ((l_q < LW'(DATA_WIDTH - 1)) && (pow_q < abs_q)) begin
          l_d   = l_q + 1'b1;
          pow_d = {pow_q[DATA_WIDTH-2:0], 1'b0};
        end else begin
          // minimum l of 1; W+l steps of long division follow
          l_d     = l_fix;
          cnt_d   = CW'(DATA_WIDTH) + CW'(l_fix);
          rem_d   = '0;
          quo_d   = '0;
          first_d = 1'b1;
          state_d = sdbi_pkg::DV_DIV;
        end
      end
      sdbi_pkg::DV_DIV: begin
        rem_d   = rem_ge ? (rem_sh - abs_q) : rem_sh;
        quo_d   = quo_nxt;
        first_d = 1'b0;
        cnt_d   = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          magic_d = quo_nxt + 1'b1;
          shift_d = l_q - 1'b1;
          state_d = sdbi_pkg::DV_IDLE;
        end
      end
      default: state_d = sdbi_pkg::DV_IDLE;
    endcase

    // a write restarts the derivation from scratch
    if (divisor_we_i) begin
      neg_d  = divisor_wdata_i[DATA_WIDTH-1];
      zero_d = (divisor_wdata_i == '0);
      abs_d  = wr_abs;
      pow_d  = DATA_WIDTH'(1);
      l_d    = '0;
      if (divisor_wdata_i == '0) begin
        magic_d = '0;
        shift_d = '0;
        state_d = sdbi_pkg::DV_IDLE;
      end else begin
        state_d = sdbi_pkg::DV_LOG;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sdbi_pkg::DV_IDLE;
      magic_q <= DATA_WIDTH'(1);
      shift_q <= '0;
      neg_q   <= 1'b0;
      zero_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      magic_q <= magic_d;
      shift_q <= shift_d;
      neg_q   <= neg_d;
      zero_q  <= zero_d;
    end
  end

  always_ff @(posedge clk_i) begin
    abs_q   <= abs_d;
    pow_q   <= pow_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    l_q     <= l_d;
    cnt_q   <= cnt_d;
    first_q <= first_d;
  end

  assign magic_o           = magic_q;
  assign shift_o           = shift_q;
  assign status_o.busy     = (state_q != sdbi_pkg::DV_IDLE);
  assign status_o.div_neg  = neg_q;
  assign status_o.div_zero = zero_q;

endmodule

// ===== src/signed_divide_by_invariant.sv =====
// ----------------------------------------------------------------------------
// signed_divide_by_invariant
// Pipeline: input register, partial products, product sum, shift/fix-up into the
// output register. Throughput: one dividend per cycle unless the output stalls or
// a divisor is being derived; each stage moves on when its successor frees up.
// A divisor write blocks input while it is taken, then for up to DATA_WIDTH
// l-search steps and DATA_WIDTH+l division steps.
// Reset: async active low; divisor 1, magic 1, post-shift 0, pipeline empty.
// ----------------------------------------------------------------------------
module signed_divide_by_invariant #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // divisor register write
  input  logic                         divisor_we_i,
  input  logic signed [DATA_WIDTH-1:0] divisor_wdata_i,
  // dividend channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [DATA_WIDTH-1:0] dividend_i,
  // quotient channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0] quotient_o,
  output logic                         divide_by_zero_o
);

  // Split of each operand for the multiply-high:
  //   x = xh * 2^LOW + xl, xh signed (HIW bits), xl unsigned (LOW bits).
  // Each partial product stays near 32x32 even at 64-bit data width.
  localparam int LW  = $clog2(DATA_WIDTH);
  localparam int LOW = DATA_WIDTH / 2;
  localparam int HIW = DATA_WIDTH - LOW;
  localparam int PW  = 2 * DATA_WIDTH;

  // --------------------------------------------------------------------------
  // Magic derivation
  // --------------------------------------------------------------------------
  logic [DATA_WIDTH-1:0] magic;
  logic [LW-1:0]         post_shift;
  sdbi_pkg::dv_status_t  dv_status;

  sdbi_magic #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_magic (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .divisor_we_i    (divisor_we_i),
    .divisor_wdata_i (divisor_wdata_i),
    .magic_o         (magic),
    .shift_o         (post_shift),
    .status_o        (dv_status)
  );

  // --------------------------------------------------------------------------
  // Pipeline flow control. A stage loads when it is empty or its successor
  // loads, so bubbles close up while the output is held.
  // --------------------------------------------------------------------------
  logic s0_vld_q, s1_vld_q, s2_vld_q, s3_vld_q;
  logic ld0, ld1, ld2, ld3;
  logic in_acc;

  assign ld3 = !s3_vld_q || !out_stall_i;
  assign ld2 = !s2_vld_q || ld3;
  assign ld1 = !s1_vld_q || ld2;
  assign ld0 = !s0_vld_q || ld1;

  // no item is taken while the magic values are being rebuilt
  assign in_stall_o = !ld0 || dv_status.busy || divisor_we_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      if (ld0) s0_vld_q <= in_acc;
      if (ld1) s1_vld_q <= s0_vld_q;
      if (ld2) s2_vld_q <= s1_vld_q;
      if (ld3) s3_vld_q <= s2_vld_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: dividend register
  // --------------------------------------------------------------------------
  logic signed [DATA_WIDTH-1:0] n0_q;

  always_ff @(posedge clk_i) begin
    if (ld0 && in_acc) begin
      n0_q <= dividend_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: four partial products of magic * n
  // --------------------------------------------------------------------------
  logic signed [HIW-1:0]   m_hi, n_hi;
  logic signed [LOW:0]     m_lo, n_lo;      // zero-extended low halves
  logic [LOW-1:0]          m_lo_u, n_lo_u;
  logic signed [2*HIW-1:0] pp_hh_d, pp_hh_q;
  logic signed [HIW+LOW:0] pp_hl_d, pp_hl_q;
  logic signed [HIW+LOW:0] pp_lh_d, pp_lh_q;
  logic [2*LOW-1:0]        pp_ll_d, pp_ll_q;
  logic signed [DATA_WIDTH-1:0] n1_q;

  assign m_hi   = magic[DATA_WIDTH-1:LOW];
  assign n_hi   = n0_q[DATA_WIDTH-1:LOW];
  assign m_lo_u = magic[LOW-1:0];
  assign n_lo_u = n0_q[LOW-1:0];
  assign m_lo   = {1'b0, m_lo_u};
  assign n_lo   = {1'b0, n_lo_u};

  assign pp_hh_d = m_hi * n_hi;
  assign pp_hl_d = m_hi * n_lo;
  assign pp_lh_d = m_lo * n_hi;
  assign pp_ll_d = m_lo_u * n_lo_u;

  always_ff @(posedge clk_i) begin
    if (ld1 && s0_vld_q) begin
      pp_hh_q <= pp_hh_d;
      pp_hl_q <= pp_hl_d;
      pp_lh_q <= pp_lh_d;
      pp_ll_q <= pp_ll_d;
      n1_q    <= n0_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: full signed product, upper half added to n (wraps at W bits)
  // --------------------------------------------------------------------------
  logic [PW-1:0]         prod_hh, prod_hl, prod_lh, prod_ll, prod;
  logic [DATA_WIDTH-1:0] q2_d;
  logic [DATA_WIDTH-1:0] q2_q;
  logic                  nneg2_q;

  assign prod_hh = {{(PW-2*HIW){pp_hh_q[2*HIW-1]}}, pp_hh_q} << (2 * LOW);
  assign prod_hl = {{(PW-HIW-LOW-1){pp_hl_q[HIW+LOW]}}, pp_hl_q} << LOW;
  assign prod_lh = {{(PW-HIW-LOW-1){pp_lh_q[HIW+LOW]}}, pp_lh_q} << LOW;
  assign prod_ll = {{(PW-2*LOW){1'b0}}, pp_ll_q};
  assign prod    = prod_hh + prod_hl + prod_lh + prod_ll;
  assign q2_d    = n1_q + prod[PW-1:DATA_WIDTH];

  always_ff @(posedge clk_i) begin
    if (ld2 && s1_vld_q) begin
      q2_q    <= q2_d;
      nneg2_q <= n1_q[DATA_WIDTH-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: arithmetic post-shift, +1 for negative n, sign of d; zero when d is 0.
  // With negative d and negative n, -(x+1) folds into ~x.
  // --------------------------------------------------------------------------
  logic signed [DATA_WIDTH-1:0] q_sh;
  logic [DATA_WIDTH-1:0]        q3_d;
  logic [DATA_WIDTH-1:0]        q3_q;
  logic                         dz3_q;

  assign q_sh = $signed(q2_q) >>> post_shift;

  always_comb begin
    priority if (dv_status.div_zero) begin
      q3_d = '0;
    end else if (dv_status.div_neg) begin
      q3_d = nneg2_q ? ~q_sh : (~q_sh + 1'b1);
    end else begin
      q3_d = nneg2_q ? (q_sh + 1'b1) : q_sh;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld3 && s2_vld_q) begin
      q3_q  <= q3_d;
      dz3_q <= dv_status.div_zero;
    end
  end

  assign out_valid_o      = s3_vld_q;
  assign quotient_o       = q3_q;
  assign divide_by_zero_o = dz3_q;

endmodule
